/* hw/rtl/abvc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abvc_pkg
// Shared widths, constants and the divider stage word of the baud calculator.
// ----------------------------------------------------------------------------
package abvc_pkg;

   localparam int FRACTION_BITS = 32;
   localparam int BAUD_W        = 24;
   localparam int CLOCK_W       = 28;
   localparam int SAMP_W        = 5;
   localparam int PROD_W        = BAUD_W + SAMP_W;
   localparam int VALUE_W       = 16;
   localparam int QUOT_W        = FRACTION_BITS + 1;
   localparam int LATENCY       = FRACTION_BITS + 4;

   typedef struct packed {
      logic                valid;
      logic                oor;
      logic [CLOCK_W-1:0]  divisor;
      logic [PROD_W-1:0]   rem;
      logic [QUOT_W-1:0]   quot;
   } abvc_stage_type;

endpackage
`default_nettype wire

/* hw/rtl/abvc_div_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abvc_div_stage
// One registered restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module abvc_div_stage (
   input  wire                          clock,
   input  wire                          reset,
   input  wire abvc_pkg::abvc_stage_type stage_d,
   output abvc_pkg::abvc_stage_type      stage_q
);

   abvc_pkg::abvc_stage_type stage_ff;
   abvc_pkg::abvc_stage_type stage_in;

   logic [abvc_pkg::PROD_W-1:0] shifted;
   logic                        ge;

   always_comb begin
      shifted  = {stage_d.rem[abvc_pkg::PROD_W-2:0], 1'b0};
      ge       = (shifted >= abvc_pkg::PROD_W'(stage_d.divisor));
      stage_in = stage_d;
      stage_in.rem  = ge ? (shifted - abvc_pkg::PROD_W'(stage_d.divisor)) : shifted;
      stage_in.quot = {stage_d.quot[abvc_pkg::QUOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_q = stage_ff;

endmodule
`default_nettype wire

/* hw/rtl/async_baud_value_calculator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// async_baud_value_calculator
// Arithmetic baud value 65536*(1 - S*B/F) through a pipelined restoring divider.
// ----------------------------------------------------------------------------
// channel   ports                                         handshake
// request   req_baud_rate, req_clock_hz, req_oversampling start & !busy
// response  rsp_baud_reg, rsp_out_of_range                 rsp_strobe, 1 cycle
//
// One word enters per cycle; busy is never raised.
// Stages in order: capture, multiply, integer quotient bit, one stage per
// fraction bit, then the final scale and output register.
// Synchronous reset drops every word in flight; no clearing pass.
// The receiver cannot stall, so nothing in the pipeline ever holds.
// ----------------------------------------------------------------------------
module async_baud_value_calculator (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire [abvc_pkg::BAUD_W-1:0]    req_baud_rate,
   input  wire [abvc_pkg::CLOCK_W-1:0]   req_clock_hz,
   input  wire [abvc_pkg::SAMP_W-1:0]    req_oversampling,
   output logic                          rsp_strobe,
   output logic [abvc_pkg::VALUE_W-1:0]  rsp_baud_reg,
   output logic                          rsp_out_of_range
);

   localparam int F = abvc_pkg::FRACTION_BITS;

   // capture
   logic                         v0_ff;
   logic [abvc_pkg::BAUD_W-1:0]  baud0_ff;
   logic [abvc_pkg::CLOCK_W-1:0] clk0_ff;
   logic [abvc_pkg::SAMP_W-1:0]  samp0_ff;

   // product
   logic                         v1_ff;
   logic [abvc_pkg::PROD_W-1:0]  prod1_ff;
   logic [abvc_pkg::PROD_W-1:0]  prod1_in;
   logic [abvc_pkg::CLOCK_W-1:0] clk1_ff;

   // integer bit
   abvc_pkg::abvc_stage_type     s2_in;
   abvc_pkg::abvc_stage_type     pipe [0:F];

   // output
   logic [F:0]                   scale;
   logic [16:0]                  top;
   logic [abvc_pkg::VALUE_W-1:0] value_in;
   logic                         strobe_ff;
   logic [abvc_pkg::VALUE_W-1:0] value_ff;
   logic                         oor_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      baud0_ff <= req_baud_rate;
      clk0_ff  <= req_clock_hz;
      samp0_ff <= req_oversampling;
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start & ~busy;
      end
   end

   assign prod1_in = abvc_pkg::PROD_W'(baud0_ff) * abvc_pkg::PROD_W'(samp0_ff);

   always_ff @(posedge clock) begin
      prod1_ff <= prod1_in;
      clk1_ff  <= clk0_ff;
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
   end

   always_comb begin
      s2_in.valid   = v1_ff;
      s2_in.divisor = clk1_ff;
      s2_in.oor     = (clk1_ff == '0) || (prod1_ff > abvc_pkg::PROD_W'(clk1_ff));
      if (prod1_ff >= abvc_pkg::PROD_W'(clk1_ff)) begin
         s2_in.rem  = prod1_ff - abvc_pkg::PROD_W'(clk1_ff);
         s2_in.quot = abvc_pkg::QUOT_W'(1);
      end else begin
         s2_in.rem  = prod1_ff;
         s2_in.quot = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe[0].valid <= 1'b0;
      end else begin
         pipe[0] <= s2_in;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < F; gi++) begin : g_div
         abvc_div_stage u_stage (
            .clock   (clock),
            .reset   (reset),
            .stage_d (pipe[gi]),
            .stage_q (pipe[gi+1])
         );
      end
   endgenerate

   always_comb begin
      scale    = {1'b1, {F{1'b0}}} - pipe[F].quot;
      top      = scale[F -: 17];
      value_in = top[16] ? {abvc_pkg::VALUE_W{1'b1}} : top[15:0];
      if (pipe[F].oor) begin
         value_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      oor_ff    <= pipe[F].oor;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= pipe[F].valid;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_baud_reg     = value_ff;
   assign rsp_out_of_range = oor_ff;

   a_oor_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_out_of_range |-> rsp_baud_reg == '0)
      else $error("out-of-range word carries a nonzero value");

   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, abvc_pkg::LATENCY))
      else $error("response without a matching request");

   a_ratio : assert property (@(posedge clock) disable iff (reset)
      pipe[F].valid && !pipe[F].oor |-> pipe[F].quot <= {1'b1, {F{1'b0}}})
      else $error("quotient above one in range");

endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for async_baud_value_calculator. Each word is scored
// against its table row's expected value where the row gives one, else a
// cycle-free model of the fixed-point baud formula 65536*(1 - S*B/F), with
// out-of-range, exact-ratio, zero-clock and zero-product handling. A short
// table of directed words comes first, then random words that are mostly in
// range, with boundary, typical, zero-operand and raw random mixes. The
// sender idles in random bursts and pauses once for a full drain.
// ----------------------------------------------------------------------------
module tb;

   localparam int RAND_WORDS     = 1450;
   localparam int QUIET_TAIL     = 150;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int DIR_ROWS       = 22;

   typedef struct packed {
      logic [abvc_pkg::VALUE_W-1:0] value;
      logic                         oor;
   } baud_result_type;

   typedef struct packed {
      logic [abvc_pkg::BAUD_W-1:0]  baud;
      logic [abvc_pkg::CLOCK_W-1:0] clk_hz;
      logic [abvc_pkg::SAMP_W-1:0]  samp;
      logic                         typed;
      logic [abvc_pkg::VALUE_W-1:0] value;
      logic                         oor;
   } stim_row_type;

   localparam stim_row_type DIR_TABLE [DIR_ROWS] = '{
      '{24'd9600,     28'd48000000,  5'd16, 1'b0, 16'd0,     1'b0},
      '{24'd115200,   28'd0,         5'd16, 1'b1, 16'd0,     1'b1},
      '{24'd0,        28'd0,         5'd0,  1'b1, 16'd0,     1'b1},
      '{24'd0,        28'd1,         5'd16, 1'b1, 16'd65535, 1'b0},
      '{24'd1,        28'd1,         5'd0,  1'b1, 16'd65535, 1'b0},
      '{24'd0,        28'hFFFFFFF,   5'd31, 1'b1, 16'd65535, 1'b0},
      '{24'd1,        28'd1,         5'd1,  1'b1, 16'd0,     1'b0},
      '{24'd1,        28'd16,        5'd16, 1'b1, 16'd0,     1'b0},
      '{24'd2,        28'd31,        5'd16, 1'b1, 16'd0,     1'b1},
      '{24'hFFFFFF,   28'hFFFFFFF,   5'd31, 1'b1, 16'd0,     1'b1},
      '{24'hFFFFFF,   28'hFFFFFFF,   5'd16, 1'b0, 16'd0,     1'b0},
      '{24'hFFFFFF,   28'hFFFFFFF,   5'd1,  1'b0, 16'd0,     1'b0},
      '{24'd1,        28'hFFFFFFF,   5'd1,  1'b0, 16'd0,     1'b0},
      '{24'd1,        28'hFFFFFFF,   5'd31, 1'b0, 16'd0,     1'b0},
      '{24'd1,        28'd2,         5'd1,  1'b0, 16'd0,     1'b0},
      '{24'd115200,   28'd8000000,   5'd8,  1'b0, 16'd0,     1'b0},
      '{24'd9600,     28'd1000000,   5'd3,  1'b0, 16'd0,     1'b0},
      '{24'hFFFFFF,   28'd268435439, 5'd16, 1'b1, 16'd0,     1'b1},
      '{24'd1000,     28'd100000,    5'd17, 1'b0, 16'd0,     1'b0},
      '{24'd3,        28'd10,        5'd3,  1'b0, 16'd0,     1'b0},
      '{24'd1,        28'd1,         5'd2,  1'b1, 16'd0,     1'b1},
      '{24'hFFFFFF,   28'd0,         5'd31, 1'b1, 16'd0,     1'b1}
   };

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          start            = 1'b0;
   logic [abvc_pkg::BAUD_W-1:0]   req_baud_rate    = '0;
   logic [abvc_pkg::CLOCK_W-1:0]  req_clock_hz     = '0;
   logic [abvc_pkg::SAMP_W-1:0]   req_oversampling = '0;
   logic                          busy;
   logic                          rsp_strobe;
   logic [abvc_pkg::VALUE_W-1:0]  rsp_baud_reg;
   logic                          rsp_out_of_range;

   baud_result_type pending_baud [$];
   int unsigned     mismatch_cnt = 0;
   int unsigned     cycle_cnt    = 0;

   async_baud_value_calculator u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_baud_rate    (req_baud_rate),
      .req_clock_hz     (req_clock_hz),
      .req_oversampling (req_oversampling),
      .rsp_strobe       (rsp_strobe),
      .rsp_baud_reg     (rsp_baud_reg),
      .rsp_out_of_range (rsp_out_of_range)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic baud_result_type calc_baud_reg(
         input logic [abvc_pkg::BAUD_W-1:0] baud,
         input logic [abvc_pkg::CLOCK_W-1:0] clk_hz,
         input logic [abvc_pkg::SAMP_W-1:0] samp);
      logic [63:0]     prod;
      logic [63:0]     ratio;
      logic [63:0]     scale;
      logic [63:0]     value;
      baud_result_type r;
      prod = 64'(samp) * 64'(baud);
      if (clk_hz == '0 || prod > 64'(clk_hz)) begin
         r.value = '0;
         r.oor   = 1'b1;
      end else begin
         ratio = (prod << abvc_pkg::FRACTION_BITS) / 64'(clk_hz);
         scale = (64'd1 << abvc_pkg::FRACTION_BITS) - ratio;
         value = (64'd65536 * scale) >> abvc_pkg::FRACTION_BITS;
         if (value > 64'd65535) begin
            value = 64'd65535;
         end
         r.value = value[abvc_pkg::VALUE_W-1:0];
         r.oor   = 1'b0;
      end
      return r;
   endfunction

   task automatic make_word(output logic [abvc_pkg::BAUD_W-1:0] baud,
                            output logic [abvc_pkg::CLOCK_W-1:0] clk_hz,
                            output logic [abvc_pkg::SAMP_W-1:0] samp);
      int unsigned sel;
      int unsigned lim;
      logic [63:0] prod;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
         case ($urandom_range(0, 3))
            0: samp = 5'd16;
            1: samp = 5'd8;
            2: samp = 5'd3;
            default: samp = 5'($urandom_range(1, 31));
         endcase
         if ($urandom_range(0, 3) == 0) begin
            clk_hz = 28'($urandom_range(1, 5000));
         end else begin
            clk_hz = 28'($urandom_range(1, 28'hFFFFFFF));
         end
         lim = 32'(clk_hz) / 32'(samp);
         if (lim > 32'hFFFFFF) begin
            lim = 32'hFFFFFF;
         end
         baud = 24'($urandom_range(0, lim));
      end else if (sel < 75) begin
         samp = 5'($urandom_range(1, 31));
         lim  = 32'h0FFFFFFF / 32'(samp);
         if (lim > 32'hFFFFFF) begin
            lim = 32'hFFFFFF;
         end
         baud   = 24'($urandom_range(1, lim));
         prod   = 64'(samp) * 64'(baud) + 64'($urandom_range(0, 2)) - 64'd1;
         clk_hz = prod[abvc_pkg::CLOCK_W-1:0];
      end else if (sel < 90) begin
         baud   = 24'($urandom);
         clk_hz = 28'($urandom);
         samp   = 5'($urandom);
      end else if (sel < 95) begin
         baud   = 24'($urandom);
         clk_hz = 28'($urandom);
         samp   = 5'($urandom);
         case ($urandom_range(0, 2))
            0: baud   = '0;
            1: samp   = '0;
            default: clk_hz = '0;
         endcase
      end else begin
         case ($urandom_range(0, 3))
            0: clk_hz = 28'd48000000;
            1: clk_hz = 28'd8000000;
            2: clk_hz = 28'd16000000;
            default: clk_hz = 28'd1000000;
         endcase
         case ($urandom_range(0, 3))
            0: baud = 24'd9600;
            1: baud = 24'd115200;
            2: baud = 24'd38400;
            default: baud = 24'd1200;
         endcase
         case ($urandom_range(0, 2))
            0: samp = 5'd16;
            1: samp = 5'd8;
            default: samp = 5'd3;
         endcase
      end
   endtask

   // Drives one word and returns at the edge that takes it.
   task automatic send_word(input logic [abvc_pkg::BAUD_W-1:0] baud,
                            input logic [abvc_pkg::CLOCK_W-1:0] clk_hz,
                            input logic [abvc_pkg::SAMP_W-1:0] samp,
                            input logic typed,
                            input baud_result_type typed_res);
      start            <= 1'b1;
      req_baud_rate    <= baud;
      req_clock_hz     <= clk_hz;
      req_oversampling <= samp;
      do @(posedge clock); while (busy);
      if (typed) begin
         pending_baud.push_back(typed_res);
      end else begin
         pending_baud.push_back(calc_baud_reg(baud, clk_hz, samp));
      end
   endtask

   always @(posedge clock) begin
      baud_result_type exp_res;
      if (!reset && rsp_strobe) begin
         if (pending_baud.size() == 0) begin
            $display("%0t: unexpected word value=%0d oor=%0b", $time,
                     rsp_baud_reg, rsp_out_of_range);
            mismatch_cnt = mismatch_cnt + 1;
         end else begin
            exp_res = pending_baud.pop_front();
            if (rsp_baud_reg !== exp_res.value) begin
               $display("%0t: baud value expected %0d actual %0d", $time,
                        exp_res.value, rsp_baud_reg);
               mismatch_cnt = mismatch_cnt + 1;
            end
            if (rsp_out_of_range !== exp_res.oor) begin
               $display("%0t: out_of_range expected %0b actual %0b", $time,
                        exp_res.oor, rsp_out_of_range);
               mismatch_cnt = mismatch_cnt + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > TIMEOUT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic [abvc_pkg::BAUD_W-1:0]  baud;
      logic [abvc_pkg::CLOCK_W-1:0] clk_hz;
      logic [abvc_pkg::SAMP_W-1:0]  samp;
      baud_result_type              typed_res;
      int unsigned                  gap;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIR_ROWS; i++) begin
         typed_res.value = DIR_TABLE[i].value;
         typed_res.oor   = DIR_TABLE[i].oor;
         send_word(DIR_TABLE[i].baud, DIR_TABLE[i].clk_hz, DIR_TABLE[i].samp,
                   DIR_TABLE[i].typed, typed_res);
      end
      typed_res = '0;
      for (int i = 0; i < RAND_WORDS; i++) begin
         make_word(baud, clk_hz, samp);
         send_word(baud, clk_hz, samp, 1'b0, typed_res);
         gap = 0;
         if (i < RAND_WORDS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
         end
         if (i == RAND_WORDS / 2) begin
            start <= 1'b0;
            while (pending_baud.size() != 0) @(posedge clock);
         end else if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      start <= 1'b0;
      while (pending_baud.size() != 0) @(posedge clock);
      repeat (abvc_pkg::LATENCY + 8) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
